FILE: hdl/ttl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_pkg: shared types and constants for the thermistor temperature lookup
// Item layout, queue status, widths and the per-entry voltage thresholds.
// ----------------------------------------------------------------------------
package ttl_pkg;

    // field widths
    localparam int MV_W           = 13;
    localparam int TEMP_W         = 7;
    localparam int STORED_ENTRIES = 66;
    localparam int IDX_W          = 7;    // bits to address STORED_ENTRIES
    localparam int PROBE_W        = 8;    // holds count + step during the search

    // decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef logic [MV_W-1:0]    t_mv;
    typedef logic [TEMP_W-1:0]  t_temp;
    typedef logic [IDX_W-1:0]   t_tidx;
    typedef logic [PROBE_W-1:0] t_probe;

    // one classified item as it travels from front to back
    typedef struct packed {
        t_mv  mv;
        logic fault;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Entry i passes (resistance <= table[i]) exactly when
    // mv >= 625000 / (table[i] + 126) + 1, so the division by mv
    // turns into a compare against a fixed voltage per entry.
    // Resistance table, descending: 275, 263, ..., 26, 25.
    localparam t_mv THR_MV [STORED_ENTRIES] = '{
        13'd1559, 13'd1607, 13'd1654, 13'd1703, 13'd1751,
        13'd1802, 13'd1850, 13'd1894, 13'd1948, 13'd1997,
        13'd2043, 13'd2098, 13'd2141, 13'd2193, 13'd2241,
        13'd2290, 13'd2341, 13'd2386, 13'd2442, 13'd2491,
        13'd2541, 13'd2583, 13'd2627, 13'd2683, 13'd2730,
        13'd2766, 13'd2816, 13'd2867, 13'd2907, 13'd2949,
        13'd2991, 13'd3034, 13'd3079, 13'd3126, 13'd3173,
        13'd3206, 13'd3256, 13'd3290, 13'd3325, 13'd3361,
        13'd3397, 13'd3435, 13'd3473, 13'd3512, 13'd3552,
        13'd3572, 13'd3613, 13'd3655, 13'd3677, 13'd3699,
        13'd3743, 13'd3766, 13'd3788, 13'd3835, 13'd3859,
        13'd3882, 13'd3907, 13'd3931, 13'd3956, 13'd3981,
        13'd4007, 13'd4033, 13'd4059, 13'd4085, 13'd4112,
        13'd4140
    };

endpackage
`default_nettype wire

FILE: hdl/ttl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_front: input side of the lookup
// Accepts voltage items, flags zero voltage and writes them to the queue.
// ----------------------------------------------------------------------------
module ttl_front (
    input  wire logic               i_valid,
    input  wire ttl_pkg::t_mv       i_millivolts,
    output logic                    o_stall,
    input  wire ttl_pkg::t_q_status i_q_status,
    output logic                    o_push,
    output ttl_pkg::t_item          o_item
);

    // stall only on a full queue (count is registered)
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // classify: zero voltage has no defined resistance
    assign o_item.mv    = i_millivolts;
    assign o_item.fault = (i_millivolts == '0);

endmodule
`default_nettype wire

FILE: hdl/ttl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_queue: short FIFO between front and back
// Lets the input keep flowing while the search pipeline is held.
// ----------------------------------------------------------------------------
module ttl_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ttl_pkg::t_item     i_item,
    input  wire logic               i_pop,
    output ttl_pkg::t_item          o_item,
    output ttl_pkg::t_q_status      o_status
);

    ttl_pkg::t_item                 r_mem [ttl_pkg::QUEUE_DEPTH];
    logic [ttl_pkg::PTR_W-1:0]      r_wr_ptr;
    logic [ttl_pkg::PTR_W-1:0]      r_rd_ptr;
    logic [ttl_pkg::CNT_W-1:0]      r_count;

    assign o_status.full  = (r_count == ttl_pkg::CNT_W'(ttl_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ttl_pkg::CNT_W'(ttl_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not lower count");

endmodule
`default_nettype wire

FILE: hdl/ttl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_back: table search pipeline and output register
// Binary search for the number of passing entries, one count bit per stage.
// ----------------------------------------------------------------------------
module ttl_back #(
    parameter int TABLE_ENTRIES = 66
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ttl_pkg::t_q_status i_q_status,
    input  wire ttl_pkg::t_item     i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ttl_pkg::t_temp          o_temperature_index,
    output logic                    o_zero_voltage_fault
);

    // searched entries, clipped to the stored table
    localparam int NS = (TABLE_ENTRIES > ttl_pkg::STORED_ENTRIES) ?
                        ttl_pkg::STORED_ENTRIES : TABLE_ENTRIES;
    localparam int CW = $clog2(NS + 1);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    // stage registers, index 0 is the item just taken from the queue
    logic                   r_vld [CW+1];
    ttl_pkg::t_mv           r_mv  [CW+1];
    logic                   r_flt [CW+1];
    logic [CW-1:0]          r_cnt [CW+1];
    logic [CW-1:0]          n_cnt [CW];

    logic                   r_out_valid;
    ttl_pkg::t_temp         r_out_idx;
    logic                   r_out_fault;
    logic                   w_adv;

    // whole pipeline advances unless the result is held
    assign w_adv = !r_out_valid || !i_stall;
    assign o_pop = w_adv && !i_q_status.empty;

    // one search step per stage: try adding the stage's power of two
    always_comb begin
        ttl_pkg::t_probe probe;
        ttl_pkg::t_tidx  sel;
        logic            fit;
        logic            take;
        for (int k = 0; k < CW; k++) begin
            probe = ttl_pkg::t_probe'(r_cnt[k]) + (ttl_pkg::t_probe'(1) << (CW - 1 - k));
            fit   = (probe <= ttl_pkg::t_probe'(NS));
            sel   = fit ? (probe[ttl_pkg::IDX_W-1:0] - ttl_pkg::t_tidx'(1)) : '0;
            take  = fit && (r_mv[k] >= ttl_pkg::THR_MV[sel]);
            n_cnt[k] = take ? probe[CW-1:0] : r_cnt[k];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CW; k++) r_vld[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= !i_q_status.empty;
            for (int k = 0; k < CW; k++) r_vld[k+1] <= r_vld[k];
            r_out_valid <= r_vld[CW];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mv[0]  <= i_item.mv;
            r_flt[0] <= i_item.fault;
            r_cnt[0] <= '0;
            for (int k = 0; k < CW; k++) begin
                r_mv[k+1]  <= r_mv[k];
                r_flt[k+1] <= r_flt[k];
                r_cnt[k+1] <= n_cnt[k];
            end
            // no passing entry maps to index zero
            if (r_cnt[CW] == '0) r_out_idx <= '0;
            else                 r_out_idx <= ttl_pkg::t_temp'(r_cnt[CW] - ONE_CNT);
            r_out_fault <= r_flt[CW];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_temperature_index  = r_out_idx;
    assign o_zero_voltage_fault = r_out_fault;

    a_fault_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_idx == '0))
        else $error("fault result with nonzero index");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_idx < ttl_pkg::t_temp'(NS)))
        else $error("index beyond searched entries");

    a_fault_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_flt[0]) |-> (r_mv[0] == '0))
        else $error("fault flag on nonzero voltage");

endmodule
`default_nettype wire

FILE: hdl/thermistor_temperature_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_temperature_lookup: divider voltage to temperature index
// Input channel: i_valid / o_stall carrying i_millivolts.
// Output channel: o_valid / i_stall carrying o_temperature_index and
// o_zero_voltage_fault. An item moves when valid is high and stall is low.
// Throughput: one item per cycle, sustained while the receiver does not stall.
// Path: each accepted item passes the queue, the search pipeline and the
// output register; the search pipeline has one stage per bit of the
// searched entry count N.
// A zero voltage raises the fault flag and returns index 0; voltages at or
// above full scale return the last entry.
// Reset (synchronous, active low) empties the queue and the pipeline; no
// table setup is needed afterward.
// When the receiver stalls, the search pipeline holds, the 4-entry queue
// keeps taking items, and o_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module thermistor_temperature_lookup #(
    parameter int TABLE_ENTRIES = 66
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire ttl_pkg::t_mv   i_millivolts,
    output logic                o_valid,
    input  wire logic           i_stall,
    output ttl_pkg::t_temp      o_temperature_index,
    output logic                o_zero_voltage_fault
);

    ttl_pkg::t_q_status w_q_status;
    ttl_pkg::t_item     w_push_item;
    ttl_pkg::t_item     w_pop_item;
    logic               w_push;
    logic               w_pop;

    // front: accept and classify
    ttl_front u_front (
        .i_valid      (i_valid),
        .i_millivolts (i_millivolts),
        .o_stall      (o_stall),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    // decoupling queue
    ttl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_q_status)
    );

    // back: table search and result
    ttl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_status           (w_q_status),
        .i_item               (w_pop_item),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_temperature_index  (o_temperature_index),
        .o_zero_voltage_fault (o_zero_voltage_fault)
    );

endmodule
`default_nettype wire
